>>> rtl/mixed_radix_time_accumulator_defines.svh
// Assertion macros for the mixed-radix time accumulator.
`ifndef MIXED_RADIX_TIME_ACCUMULATOR_DEFINES_SVH
`define MIXED_RADIX_TIME_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS
`define MRTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define MRTA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MRTA_ASSERT_IMP(lbl, ante, cons, msg)
`define MRTA_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/mrta_pkg.sv
// Types, codes and constants shared by the mixed-radix time accumulator.
`default_nettype none

package mrta_pkg;

  localparam int MILLI_WIDTH_DEF = 10;
  localparam int YEAR_WIDTH_DEF  = 12;

  localparam int MILLI_REG_W = 10;
  localparam int SEC_W       = 6;
  localparam int MIN_W       = 6;
  localparam int HOUR_W      = 5;
  localparam int DAY_W       = 5;
  localparam int MON_W       = 4;
  localparam int YEAR_REG_W  = 12;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  // Fields below the year: milli, second, minute, hour, day, month.
  localparam int NF    = 6;
  localparam int FLD_W = 3;

  localparam logic [MILLI_REG_W-1:0] MILLI_MAX_RST  = 10'd999;
  localparam logic [SEC_W-1:0]       SECOND_MAX_RST = 6'd59;
  localparam logic [MIN_W-1:0]       MINUTE_MAX_RST = 6'd59;
  localparam logic [HOUR_W-1:0]      HOUR_MAX_RST   = 5'd23;
  localparam logic [DAY_W-1:0]       DAY_MAX_RST    = 5'd30;
  localparam logic [MON_W-1:0]       MONTH_MAX_RST  = 4'd11;
  localparam logic [YEAR_REG_W-1:0]  YEAR_MAX_RST   = 12'd4095;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_LOAD  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BADOP = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MILLI_MAX  = 3'd0,
    CFG_SECOND_MAX = 3'd1,
    CFG_MINUTE_MAX = 3'd2,
    CFG_HOUR_MAX   = 3'd3,
    CFG_DAY_MAX    = 3'd4,
    CFG_MONTH_MAX  = 3'd5,
    CFG_YEAR_MAX   = 3'd6
  } cfg_idx_e;

endpackage

`default_nettype wire

>>> rtl/mrta_div.sv
// Restoring divider, one quotient bit per cycle, for carries out of oversized fields.
`default_nettype none

module mrta_div
  import mrta_pkg::*;
#(
  parameter int DIVIDEND_W = MILLI_WIDTH_DEF + 2,
  parameter int DIVISOR_W  = MILLI_WIDTH_DEF + 1
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  input  wire logic [DIVIDEND_W-1:0] dividend_i,
  input  wire logic [DIVISOR_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [DIVIDEND_W-1:0]      quot_o,
  output logic [DIVISOR_W-1:0]       rem_o
);

  localparam int CNT_W = $clog2(DIVIDEND_W);

  logic                  busy_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dvs_q;
  logic [DIVISOR_W:0]    trial;
  logic                  ge;

  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
      rem_q <= ge ? DIVISOR_W'(trial - {1'b0, dvs_q}) : trial[DIVISOR_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

>>> rtl/mixed_radix_time_accumulator.sv
// Top level of the mixed-radix time accumulator: command stage, carry logic and result.
//
//   Channel  Direction  Handshake                  Payload
//   in       input      in_valid_i / in_ready_o    cmd_i, op_year_i .. op_milli_i
//   out      output     out_valid_o / out_ready_i  status_o, res_year_o .. res_milli_o, is_zero_o
//   cfg      input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A command is registered on transfer and its result is registered when it commits; one command
// is taken per cycle while every accumulator field is within its maximum and the output is free.
// An add while some field is above its maximum uses the restoring divider for each of the
// six lower fields in turn, carrying each quotient into the next field.
// The accumulator doubles as the result register and only changes when a result is issued,
// so a stalled output holds it. Reset clears the accumulator and restores the maxima.
`default_nettype none

`include "mixed_radix_time_accumulator_defines.svh"

module mixed_radix_time_accumulator
  import mrta_pkg::*;
#(
  parameter int YEAR_WIDTH  = YEAR_WIDTH_DEF,
  parameter int MILLI_WIDTH = MILLI_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire logic [1:0]             cmd_i,
  input  wire logic [YEAR_WIDTH-1:0]  op_year_i,
  input  wire logic [MON_W-1:0]       op_month_i,
  input  wire logic [DAY_W-1:0]       op_day_i,
  input  wire logic [HOUR_W-1:0]      op_hour_i,
  input  wire logic [MIN_W-1:0]       op_minute_i,
  input  wire logic [SEC_W-1:0]       op_second_i,
  input  wire logic [MILLI_WIDTH-1:0] op_milli_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [1:0]                  status_o,
  output logic [YEAR_WIDTH-1:0]       res_year_o,
  output logic [MON_W-1:0]            res_month_o,
  output logic [DAY_W-1:0]            res_day_o,
  output logic [HOUR_W-1:0]           res_hour_o,
  output logic [MIN_W-1:0]            res_minute_o,
  output logic [SEC_W-1:0]            res_second_o,
  output logic [MILLI_WIDTH-1:0]      res_milli_o,
  output logic                        is_zero_o,
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int FW  = MILLI_WIDTH;
  localparam int SW  = MILLI_WIDTH + 2;
  localparam int DW  = MILLI_WIDTH + 1;
  localparam int YLW = (YEAR_WIDTH > YEAR_REG_W) ? YEAR_WIDTH : YEAR_REG_W;
  localparam int YSW = ((YEAR_WIDTH > SW) ? YEAR_WIDTH : SW) + 1;
  localparam logic [FLD_W-1:0] LAST_FLD = FLD_W'(NF - 1);

  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_LOAD = 2'd1;
  localparam logic [1:0] SEQ_WAIT = 2'd2;
  localparam logic [1:0] SEQ_DONE = 2'd3;

  // Maxima
  logic [MILLI_REG_W-1:0] milli_max_q;
  logic [SEC_W-1:0]       second_max_q;
  logic [MIN_W-1:0]       minute_max_q;
  logic [HOUR_W-1:0]      hour_max_q;
  logic [DAY_W-1:0]       day_max_q;
  logic [MON_W-1:0]       month_max_q;
  logic [YEAR_REG_W-1:0]  year_max_q;

  // Accumulator
  logic [YEAR_WIDTH-1:0]  acc_year_q;
  logic [MON_W-1:0]       acc_month_q;
  logic [DAY_W-1:0]       acc_day_q;
  logic [HOUR_W-1:0]      acc_hour_q;
  logic [MIN_W-1:0]       acc_minute_q;
  logic [SEC_W-1:0]       acc_second_q;
  logic [MILLI_WIDTH-1:0] acc_milli_q;

  // Command stage
  logic                   s1_valid_q;
  cmd_e                   s1_cmd_q;
  logic [YEAR_WIDTH-1:0]  s1_year_q;
  logic [MON_W-1:0]       s1_month_q;
  logic [DAY_W-1:0]       s1_day_q;
  logic [HOUR_W-1:0]      s1_hour_q;
  logic [MIN_W-1:0]       s1_minute_q;
  logic [SEC_W-1:0]       s1_second_q;
  logic [MILLI_WIDTH-1:0] s1_milli_q;

  logic                   out_valid_q;
  status_e                status_q;
  status_e                status_d;

  logic [FW-1:0]          acc_a [NF];
  logic [FW-1:0]          op_a  [NF];
  logic [FW-1:0]          mx_a  [NF];
  logic [FW-1:0]          add_a [NF];
  logic [FW-1:0]          sub_a [NF];
  logic [FW-1:0]          nacc_a [NF];
  logic [FW-1:0]          nxt_q [NF];
  logic [YEAR_WIDTH-1:0]  nacc_year;

  logic [YLW-1:0]         ymax_w;
  logic [YLW-1:0]         ymask_w;
  logic [YEAR_WIDTH-1:0]  ylim;

  logic                   bad_op;
  logic                   above_max;
  logic                   slow_needed;
  logic                   out_free;
  logic                   commit;

  logic [YEAR_WIDTH:0]    add_year;
  logic                   add_ovf;
  logic                   sub_unf;
  logic [YEAR_WIDTH-1:0]  sub_year;
  logic [YSW-1:0]         slow_year;
  logic                   slow_ovf;

  logic [1:0]             seq_q;
  logic [FLD_W-1:0]       fld_q;
  logic [SW-1:0]          carry_q;
  logic                   div_start;
  logic                   div_done;
  logic [SW-1:0]          div_quot;
  logic [DW-1:0]          div_rem;
  logic [SW-1:0]          div_dividend;
  logic [DW-1:0]          div_divisor;

  assign acc_a[0] = acc_milli_q;
  assign acc_a[1] = FW'(acc_second_q);
  assign acc_a[2] = FW'(acc_minute_q);
  assign acc_a[3] = FW'(acc_hour_q);
  assign acc_a[4] = FW'(acc_day_q);
  assign acc_a[5] = FW'(acc_month_q);

  assign op_a[0] = s1_milli_q;
  assign op_a[1] = FW'(s1_second_q);
  assign op_a[2] = FW'(s1_minute_q);
  assign op_a[3] = FW'(s1_hour_q);
  assign op_a[4] = FW'(s1_day_q);
  assign op_a[5] = FW'(s1_month_q);

  assign mx_a[0] = FW'(milli_max_q);
  assign mx_a[1] = FW'(second_max_q);
  assign mx_a[2] = FW'(minute_max_q);
  assign mx_a[3] = FW'(hour_max_q);
  assign mx_a[4] = FW'(day_max_q);
  assign mx_a[5] = FW'(month_max_q);

  assign ymax_w  = YLW'(year_max_q);
  assign ymask_w = YLW'({YEAR_WIDTH{1'b1}});
  assign ylim    = (ymax_w > ymask_w) ? YEAR_WIDTH'(ymask_w) : YEAR_WIDTH'(ymax_w);

  always_comb begin
    bad_op    = (s1_year_q > ylim);
    above_max = 1'b0;
    for (int i = 0; i < NF; i++) begin
      if (op_a[i] > mx_a[i]) bad_op = 1'b1;
      if (acc_a[i] > mx_a[i]) above_max = 1'b1;
    end
  end

  assign slow_needed = s1_valid_q && (s1_cmd_q == CMD_ADD) && !bad_op && above_max;
  assign out_free    = !out_valid_q || out_ready_i;
  assign commit      = s1_valid_q && out_free && (!slow_needed || (seq_q == SEQ_DONE));
  assign in_ready_o  = !s1_valid_q || commit;
  assign cfg_ready_o = 1'b1;

  // Carry chain for add, valid when no field sits above its maximum.
  always_comb begin
    logic          c;
    logic [FW:0]   s;
    logic [FW:0]   r;
    c = 1'b0;
    for (int i = 0; i < NF; i++) begin
      s = (FW+1)'(acc_a[i]) + (FW+1)'(op_a[i]) + (FW+1)'(c);
      r = (FW+1)'(mx_a[i]) + 1'b1;
      if (s >= r) begin
        add_a[i] = FW'(s - r);
        c        = 1'b1;
      end else begin
        add_a[i] = FW'(s);
        c        = 1'b0;
      end
    end
    add_year = (YEAR_WIDTH+1)'(acc_year_q) + (YEAR_WIDTH+1)'(s1_year_q)
             + (YEAR_WIDTH+1)'(c);
    add_ovf  = (add_year > (YEAR_WIDTH+1)'(ylim));
  end

  // Borrow chain for subtract.
  always_comb begin
    logic            b;
    logic [FW:0]     need;
    logic [FW+1:0]   wrap;
    logic [YEAR_WIDTH:0] yneed;
    b = 1'b0;
    for (int i = 0; i < NF; i++) begin
      need = (FW+1)'(op_a[i]) + (FW+1)'(b);
      wrap = (FW+2)'(acc_a[i]) + (FW+2)'(mx_a[i]) + 1'b1 - (FW+2)'(need);
      if ((FW+1)'(acc_a[i]) < need) begin
        sub_a[i] = FW'(wrap);
        b        = 1'b1;
      end else begin
        sub_a[i] = FW'((FW+1)'(acc_a[i]) - need);
        b        = 1'b0;
      end
    end
    yneed    = (YEAR_WIDTH+1)'(s1_year_q) + (YEAR_WIDTH+1)'(b);
    sub_unf  = ((YEAR_WIDTH+1)'(acc_year_q) < yneed);
    sub_year = YEAR_WIDTH'((YEAR_WIDTH+1)'(acc_year_q) - yneed);
  end

  assign slow_year = YSW'(acc_year_q) + YSW'(s1_year_q) + YSW'(carry_q);
  assign slow_ovf  = (slow_year > YSW'(ylim));

  always_comb begin
    status_d  = ST_OK;
    nacc_a    = acc_a;
    nacc_year = acc_year_q;
    case (s1_cmd_q)
      CMD_CLEAR: begin
        for (int i = 0; i < NF; i++) nacc_a[i] = '0;
        nacc_year = '0;
      end
      CMD_LOAD: begin
        if (bad_op) begin
          status_d = ST_BADOP;
        end else begin
          nacc_a    = op_a;
          nacc_year = s1_year_q;
        end
      end
      CMD_ADD: begin
        if (bad_op) begin
          status_d = ST_BADOP;
        end else if (above_max) begin
          if (slow_ovf) begin
            status_d = ST_RANGE;
          end else begin
            nacc_a    = nxt_q;
            nacc_year = YEAR_WIDTH'(slow_year);
          end
        end else if (add_ovf) begin
          status_d = ST_RANGE;
        end else begin
          nacc_a    = add_a;
          nacc_year = YEAR_WIDTH'(add_year);
        end
      end
      CMD_SUB: begin
        if (bad_op) begin
          status_d = ST_BADOP;
        end else if (sub_unf) begin
          status_d = ST_RANGE;
        end else begin
          nacc_a    = sub_a;
          nacc_year = sub_year;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      milli_max_q  <= MILLI_MAX_RST;
      second_max_q <= SECOND_MAX_RST;
      minute_max_q <= MINUTE_MAX_RST;
      hour_max_q   <= HOUR_MAX_RST;
      day_max_q    <= DAY_MAX_RST;
      month_max_q  <= MONTH_MAX_RST;
      year_max_q   <= YEAR_MAX_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_MILLI_MAX:  milli_max_q  <= cfg_data_i[MILLI_REG_W-1:0];
        CFG_SECOND_MAX: second_max_q <= cfg_data_i[SEC_W-1:0];
        CFG_MINUTE_MAX: minute_max_q <= cfg_data_i[MIN_W-1:0];
        CFG_HOUR_MAX:   hour_max_q   <= cfg_data_i[HOUR_W-1:0];
        CFG_DAY_MAX:    day_max_q    <= cfg_data_i[DAY_W-1:0];
        CFG_MONTH_MAX:  month_max_q  <= cfg_data_i[MON_W-1:0];
        CFG_YEAR_MAX:   year_max_q   <= cfg_data_i[YEAR_REG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      acc_year_q   <= '0;
      acc_month_q  <= '0;
      acc_day_q    <= '0;
      acc_hour_q   <= '0;
      acc_minute_q <= '0;
      acc_second_q <= '0;
      acc_milli_q  <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (commit) begin
        s1_valid_q <= 1'b0;
      end
      if (commit) begin
        out_valid_q  <= 1'b1;
        status_q     <= status_d;
        acc_milli_q  <= nacc_a[0];
        acc_second_q <= nacc_a[1][SEC_W-1:0];
        acc_minute_q <= nacc_a[2][MIN_W-1:0];
        acc_hour_q   <= nacc_a[3][HOUR_W-1:0];
        acc_day_q    <= nacc_a[4][DAY_W-1:0];
        acc_month_q  <= nacc_a[5][MON_W-1:0];
        acc_year_q   <= nacc_year;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_cmd_q    <= cmd_e'(cmd_i);
      s1_year_q   <= op_year_i;
      s1_month_q  <= op_month_i;
      s1_day_q    <= op_day_i;
      s1_hour_q   <= op_hour_i;
      s1_minute_q <= op_minute_i;
      s1_second_q <= op_second_i;
      s1_milli_q  <= op_milli_i;
    end
  end

  // Long-division sequence over the six lower fields.
  assign div_start    = (seq_q == SEQ_LOAD);
  assign div_dividend = SW'(acc_a[fld_q]) + SW'(op_a[fld_q]) + carry_q;
  assign div_divisor  = DW'(mx_a[fld_q]) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SEQ_IDLE;
      fld_q   <= '0;
      carry_q <= '0;
    end else begin
      case (seq_q)
        SEQ_IDLE: begin
          if (slow_needed) begin
            fld_q   <= '0;
            carry_q <= '0;
            seq_q   <= SEQ_LOAD;
          end
        end
        SEQ_LOAD: begin
          seq_q <= SEQ_WAIT;
        end
        SEQ_WAIT: begin
          if (div_done) begin
            carry_q <= div_quot;
            if (fld_q == LAST_FLD) begin
              seq_q <= SEQ_DONE;
            end else begin
              fld_q <= fld_q + 1'b1;
              seq_q <= SEQ_LOAD;
            end
          end
        end
        SEQ_DONE: begin
          if (commit) seq_q <= SEQ_IDLE;
        end
        default: begin
          seq_q <= SEQ_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((seq_q == SEQ_WAIT) && div_done) begin
      nxt_q[fld_q] <= FW'(div_rem);
    end
  end

  mrta_div #(
    .DIVIDEND_W (SW),
    .DIVISOR_W  (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign res_year_o   = acc_year_q;
  assign res_month_o  = acc_month_q;
  assign res_day_o    = acc_day_q;
  assign res_hour_o   = acc_hour_q;
  assign res_minute_o = acc_minute_q;
  assign res_second_o = acc_second_q;
  assign res_milli_o  = acc_milli_q;
  assign is_zero_o    = ~|{acc_year_q, acc_month_q, acc_day_q, acc_hour_q,
                           acc_minute_q, acc_second_q, acc_milli_q};

  `MRTA_ASSERT_IMP(a_seq_only_for_add, seq_q != SEQ_IDLE,
                   s1_valid_q && (s1_cmd_q == CMD_ADD), "division sequence without an add")
  `MRTA_ASSERT_NXT(a_clear_gives_zero, commit && (s1_cmd_q == CMD_CLEAR),
                   (status_q == ST_OK) && is_zero_o, "clear did not zero the accumulator")
  `MRTA_ASSERT_NXT(a_error_keeps_acc, commit && (status_d != ST_OK),
                   $stable(acc_year_q) && $stable(acc_milli_q) && $stable(acc_month_q),
                   "accumulator changed on an error")

endmodule

`default_nettype wire
